@@ rtl/core/pixel_format_to_argb32_top_assert.svh @@
// Assertion macros used by the top-level RTL file of the pixel format converter.
`ifndef PIXEL_FORMAT_TO_ARGB32_TOP_ASSERT_SVH
`define PIXEL_FORMAT_TO_ARGB32_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pixel format converter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pixel format converter: next-cycle check failed");

`endif

@@ rtl/core/pfa_pkg.sv @@
`default_nettype none
package pfa_pkg;

	localparam int unsigned CfgDataW = 13;
	localparam int unsigned CfgIndexW = 3;

	localparam logic [2:0] FMT_RGB565 = 3'd0;
	localparam logic [2:0] FMT_RGB888 = 3'd1;
	localparam logic [2:0] FMT_XRGB32 = 3'd2;
	localparam logic [2:0] FMT_RGBA_PREMUL = 3'd3;
	localparam logic [2:0] FMT_ARGB32 = 3'd4;

	localparam logic [CfgIndexW-1:0] REG_PIXEL_FORMAT = 3'd0;
	localparam logic [CfgIndexW-1:0] REG_IMAGE_WIDTH = 3'd1;
	localparam logic [CfgIndexW-1:0] REG_IMAGE_HEIGHT = 3'd2;
	localparam logic [CfgIndexW-1:0] REG_RECT_X = 3'd3;
	localparam logic [CfgIndexW-1:0] REG_RECT_Y = 3'd4;
	localparam logic [CfgIndexW-1:0] REG_RECT_WIDTH = 3'd5;
	localparam logic [CfgIndexW-1:0] REG_RECT_HEIGHT = 3'd6;

	typedef struct packed {
		logic [2:0] pixel_format;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [11:0] rect_x;
		logic [11:0] rect_y;
		logic [9:0] rect_width;
		logic [9:0] rect_height;
	} cfg_t;

	typedef struct packed {
		logic outside;
		logic last;
	} pos_t;

endpackage
`default_nettype wire

@@ rtl/core/pfa_cfg_regs.sv @@
`default_nettype none
module pfa_cfg_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [pfa_pkg::CfgIndexW-1:0] cfg_index,
	input wire logic [pfa_pkg::CfgDataW-1:0] cfg_data,
	output pfa_pkg::cfg_t cfg
);

	pfa_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_format <= pfa_pkg::FMT_RGB565;
			cfg_q.image_width <= 13'd1;
			cfg_q.image_height <= 13'd1;
			cfg_q.rect_x <= 12'd0;
			cfg_q.rect_y <= 12'd0;
			cfg_q.rect_width <= 10'd1;
			cfg_q.rect_height <= 10'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pfa_pkg::REG_PIXEL_FORMAT: cfg_q.pixel_format <= cfg_data[2:0];
				pfa_pkg::REG_IMAGE_WIDTH: cfg_q.image_width <= cfg_data[12:0];
				pfa_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[12:0];
				pfa_pkg::REG_RECT_X: cfg_q.rect_x <= cfg_data[11:0];
				pfa_pkg::REG_RECT_Y: cfg_q.rect_y <= cfg_data[11:0];
				pfa_pkg::REG_RECT_WIDTH: cfg_q.rect_width <= cfg_data[9:0];
				pfa_pkg::REG_RECT_HEIGHT: cfg_q.rect_height <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ rtl/core/pfa_position.sv @@
`default_nettype none
module pfa_position #(
	parameter int unsigned MAX_TILE = 512,
	parameter int unsigned MAX_IMAGE = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic advance,
	input wire pfa_pkg::cfg_t cfg,
	output pfa_pkg::pos_t pos
);

	localparam int unsigned CntW = (MAX_TILE > 1) ? $clog2(MAX_TILE) : 1;
	localparam int unsigned ImgW = $clog2(MAX_IMAGE + 1);
	localparam int unsigned CmpW = (ImgW > 14) ? ImgW : 14;

	logic [CntW-1:0] col_q;
	logic [CntW-1:0] row_q;
	logic [CmpW-1:0] tile_w;
	logic [CmpW-1:0] tile_h;
	logic [CmpW-1:0] img_w;
	logic [CmpW-1:0] img_h;
	logic [CmpW-1:0] col_x;
	logic [CmpW-1:0] row_y;
	logic end_col;
	logic end_row;

	always_comb begin
		if (cfg.rect_width == 10'd0) begin
			tile_w = CmpW'(1);
		end else if (CmpW'(cfg.rect_width) > CmpW'(MAX_TILE)) begin
			tile_w = CmpW'(MAX_TILE);
		end else begin
			tile_w = CmpW'(cfg.rect_width);
		end
		if (cfg.rect_height == 10'd0) begin
			tile_h = CmpW'(1);
		end else if (CmpW'(cfg.rect_height) > CmpW'(MAX_TILE)) begin
			tile_h = CmpW'(MAX_TILE);
		end else begin
			tile_h = CmpW'(cfg.rect_height);
		end
		img_w = (CmpW'(cfg.image_width) > CmpW'(MAX_IMAGE)) ? CmpW'(MAX_IMAGE)
			: CmpW'(cfg.image_width);
		img_h = (CmpW'(cfg.image_height) > CmpW'(MAX_IMAGE)) ? CmpW'(MAX_IMAGE)
			: CmpW'(cfg.image_height);
		col_x = CmpW'(cfg.rect_x) + CmpW'(col_q);
		row_y = CmpW'(cfg.rect_y) + CmpW'(row_q);
		end_col = CmpW'(col_q) >= (tile_w - CmpW'(1));
		end_row = CmpW'(row_q) >= (tile_h - CmpW'(1));
	end

	assign pos.outside = (col_x >= img_w) || (row_y >= img_h);
	assign pos.last = end_col && end_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (end_col) begin
				col_q <= '0;
				row_q <= end_row ? '0 : row_q + CntW'(1);
			end else begin
				col_q <= col_q + CntW'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/pfa_convert.sv @@
`default_nettype none
module pfa_convert (
	input wire logic [2:0] pixel_format,
	input wire logic [31:0] raw,
	input wire logic outside,
	output logic [31:0] argb
);

	function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
		logic [16:0] t;
		logic [16:0] s;
		t = 17'(16'(c) * 16'(a)) + 17'h80;
		s = t + (t >> 8);
		return s[15:8];
	endfunction

	logic [7:0] r565;
	logic [7:0] g565;
	logic [7:0] b565;
	logic [31:0] conv;

	assign r565 = {raw[15:11], raw[15:13]};
	assign g565 = {raw[10:5], raw[10:9]};
	assign b565 = {raw[4:0], raw[4:2]};

	always_comb begin
		unique case (pixel_format)
			pfa_pkg::FMT_RGB565: conv = {8'hff, r565, g565, b565};
			pfa_pkg::FMT_RGB888: conv = {8'hff, raw[7:0], raw[15:8], raw[23:16]};
			pfa_pkg::FMT_XRGB32: conv = {8'hff, raw[23:0]};
			pfa_pkg::FMT_RGBA_PREMUL: conv = {raw[31:24], premul(raw[7:0], raw[31:24]),
				premul(raw[15:8], raw[31:24]), premul(raw[23:16], raw[31:24])};
			pfa_pkg::FMT_ARGB32: conv = raw;
			default: conv = 32'd0;
		endcase
	end

	assign argb = outside ? 32'd0 : conv;

endmodule
`default_nettype wire

@@ rtl/core/pixel_format_to_argb32_top.sv @@
// Channel   Direction  Handshake            Payload
// in        sink       in_valid/in_stall    raw_pixel
// out       source     out_valid/out_stall  argb_pixel, padded, last
// cfg       sink       cfg_we               cfg_index, cfg_data
//
// One pixel per clock is accepted while in_stall is low; each result is presented from the
// result register once its input transaction has passed the input register.
// The latency is set by the input register and the result register around the converter.
// Reset clears the valid bits, the rectangle counters and the configuration registers to their defaults.
// A stall on the output backs up through both stages to in_stall in the same cycle.
`default_nettype none
`include "pixel_format_to_argb32_top_assert.svh"
module pixel_format_to_argb32_top #(
	parameter int unsigned MAX_TILE = 512,
	parameter int unsigned MAX_IMAGE = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [pfa_pkg::CfgIndexW-1:0] cfg_index,
	input wire logic [pfa_pkg::CfgDataW-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [31:0] raw_pixel,
	output logic out_valid,
	input wire logic out_stall,
	output logic [31:0] argb_pixel,
	output logic padded,
	output logic last
);

	pfa_pkg::cfg_t cfg;
	pfa_pkg::pos_t pos;
	pfa_pkg::pos_t pos_s1;
	logic valid_s1;
	logic valid_s2;
	logic [31:0] raw_s1;
	logic [31:0] argb_s2;
	logic padded_s2;
	logic last_s2;
	logic [31:0] argb_next;
	logic take_s2;
	logic take_s1;

	pfa_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	pfa_position #(
		.MAX_TILE(MAX_TILE),
		.MAX_IMAGE(MAX_IMAGE)
	) u_pos (
		.clk(clk),
		.arst_n(arst_n),
		.advance(take_s1),
		.cfg(cfg),
		.pos(pos)
	);

	pfa_convert u_conv (
		.pixel_format(cfg.pixel_format),
		.raw(raw_s1),
		.outside(pos_s1.outside),
		.argb(argb_next)
	);

	assign take_s2 = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !take_s2;
	assign take_s1 = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (take_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			raw_s1 <= raw_pixel;
			pos_s1 <= pos;
		end
		if (take_s2 && valid_s1) begin
			argb_s2 <= argb_next;
			padded_s2 <= pos_s1.outside;
			last_s2 <= pos_s1.last;
		end
	end

	assign out_valid = valid_s2;
	assign argb_pixel = argb_s2;
	assign padded = padded_s2;
	assign last = last_s2;

	`PFA_ASSERT_SAME(a_stall_needs_full, clk, arst_n, in_stall, valid_s1 && valid_s2)
	`PFA_ASSERT_SAME(a_padded_is_zero, clk, arst_n, out_valid && padded, argb_pixel == 32'd0)
	`PFA_ASSERT_NEXT(a_s1_moves_on, clk, arst_n, valid_s1 && !valid_s2, out_valid)

endmodule
`default_nettype wire

@@ test/pixel_format_to_argb32_top_test.sv @@
`timescale 1ns / 1ps
module pixel_format_to_argb32_top_test;

	localparam int unsigned TILE_LIMIT = 512;
	localparam int unsigned IMAGE_LIMIT = 4096;
	localparam logic [pfa_pkg::CfgIndexW-1:0] REG_UNUSED_INDEX = 3'd7;
	localparam int unsigned REPORT_LINES = 40;

	typedef struct packed {
		logic [31:0] argb;
		logic padded;
		logic last;
	} argb_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [pfa_pkg::CfgIndexW-1:0] cfg_index;
	logic [pfa_pkg::CfgDataW-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [31:0] raw_pixel;
	logic out_valid;
	logic out_stall;
	logic [31:0] argb_pixel;
	logic padded;
	logic last;

	pfa_pkg::cfg_t reg_shadow;
	int unsigned col_pos;
	int unsigned row_pos;
	argb_result_t pending_argb[$];
	int unsigned mismatch_count;
	int unsigned pixels_sent;
	int unsigned reg_writes;
	int unsigned send_idle_pct;
	int unsigned stall_pct;

	pixel_format_to_argb32_top #(
		.MAX_TILE(TILE_LIMIT),
		.MAX_IMAGE(IMAGE_LIMIT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.raw_pixel(raw_pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.argb_pixel(argb_pixel),
		.padded(padded),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("pixel_format_to_argb32_top test failed");
		$finish;
	end

	function automatic logic [7:0] premultiply(logic [7:0] c, logic [7:0] a);
		int unsigned t;
		t = c * a + 32'h80;
		return 8'((t + (t >> 8)) >> 8);
	endfunction

	function automatic logic [31:0] convert_raw(logic [2:0] fmt, logic [31:0] raw);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
		case (fmt)
			pfa_pkg::FMT_RGB565: begin
				r = {raw[15:11], raw[15:13]};
				g = {raw[10:5], raw[10:9]};
				b = {raw[4:0], raw[4:2]};
				return {8'hFF, r, g, b};
			end
			pfa_pkg::FMT_RGB888: return {8'hFF, raw[7:0], raw[15:8], raw[23:16]};
			pfa_pkg::FMT_XRGB32: return {8'hFF, raw[23:0]};
			pfa_pkg::FMT_RGBA_PREMUL: begin
				a = raw[31:24];
				return {a, premultiply(raw[7:0], a), premultiply(raw[15:8], a),
					premultiply(raw[23:16], a)};
			end
			pfa_pkg::FMT_ARGB32: return raw;
			default: return '0;
		endcase
	endfunction

	function automatic void predict_position(logic [31:0] raw);
		int unsigned w;
		int unsigned h;
		int unsigned iw;
		int unsigned ih;
		logic end_col;
		logic end_row;
		logic outside;
		argb_result_t r;
		w = (reg_shadow.rect_width == 0) ? 1 :
			((reg_shadow.rect_width > TILE_LIMIT) ? TILE_LIMIT : reg_shadow.rect_width);
		h = (reg_shadow.rect_height == 0) ? 1 :
			((reg_shadow.rect_height > TILE_LIMIT) ? TILE_LIMIT : reg_shadow.rect_height);
		iw = (reg_shadow.image_width > IMAGE_LIMIT) ? IMAGE_LIMIT : reg_shadow.image_width;
		ih = (reg_shadow.image_height > IMAGE_LIMIT) ? IMAGE_LIMIT : reg_shadow.image_height;
		end_col = col_pos >= w - 1;
		end_row = row_pos >= h - 1;
		outside = (reg_shadow.rect_x + col_pos >= iw) || (reg_shadow.rect_y + row_pos >= ih);
		r.argb = outside ? 32'h0 : convert_raw(reg_shadow.pixel_format, raw);
		r.padded = outside;
		r.last = end_col && end_row;
		pending_argb.push_back(r);
		if (end_col) begin
			col_pos = 0;
			row_pos = end_row ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatch_count < REPORT_LINES) begin
			$display("%0t: %s mismatch: got %08h, expected %08h", $time, what, got, want);
		end
		mismatch_count++;
	endtask

	always @(posedge clk) begin : check_results
		argb_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_argb.size() == 0) begin
				report_mismatch("unexpected transaction", argb_pixel, 32'h0);
			end else begin
				want = pending_argb.pop_front();
				if (argb_pixel !== want.argb) begin
					report_mismatch("argb_pixel", argb_pixel, want.argb);
				end
				if (padded !== want.padded) begin
					report_mismatch("padded", 32'(padded), 32'(want.padded));
				end
				if (last !== want.last) begin
					report_mismatch("last", 32'(last), 32'(want.last));
				end
			end
		end
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic set_flow(input int unsigned send_pct, input int unsigned recv_pct);
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
	endtask

	task automatic write_reg(input logic [pfa_pkg::CfgIndexW-1:0] idx,
		input int unsigned value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= pfa_pkg::CfgDataW'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			pfa_pkg::REG_PIXEL_FORMAT: reg_shadow.pixel_format = value[2:0];
			pfa_pkg::REG_IMAGE_WIDTH: reg_shadow.image_width = value[12:0];
			pfa_pkg::REG_IMAGE_HEIGHT: reg_shadow.image_height = value[12:0];
			pfa_pkg::REG_RECT_X: reg_shadow.rect_x = value[11:0];
			pfa_pkg::REG_RECT_Y: reg_shadow.rect_y = value[11:0];
			pfa_pkg::REG_RECT_WIDTH: reg_shadow.rect_width = value[9:0];
			pfa_pkg::REG_RECT_HEIGHT: reg_shadow.rect_height = value[9:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic send_pixel(input logic [31:0] raw);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			raw_pixel <= $urandom;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		raw_pixel <= raw;
		do @(posedge clk); while (in_stall);
		predict_position(raw);
		pixels_sent++;
	endtask

	// Registers may only change once the pipeline has emptied.
	task automatic settle_idle;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_argb.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_reset_defaults;
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0000_0000);
	endtask

	task automatic test_formats;
		settle_idle();
		write_reg(pfa_pkg::REG_PIXEL_FORMAT, 32'(pfa_pkg::FMT_RGB565));
		send_pixel(32'hA5A5_F81F);
		send_pixel(32'h0000_07E0);
		settle_idle();
		write_reg(pfa_pkg::REG_PIXEL_FORMAT, 32'(pfa_pkg::FMT_RGB888));
		send_pixel(32'hFF12_3456);
		settle_idle();
		write_reg(pfa_pkg::REG_PIXEL_FORMAT, 32'(pfa_pkg::FMT_XRGB32));
		send_pixel(32'h5A80_C0FF);
		settle_idle();
		write_reg(pfa_pkg::REG_PIXEL_FORMAT, 32'(pfa_pkg::FMT_RGBA_PREMUL));
		send_pixel(32'hFF80_40FF);
		send_pixel(32'h00FF_FFFF);
		send_pixel(32'h80FF_0001);
		settle_idle();
		write_reg(pfa_pkg::REG_PIXEL_FORMAT, 32'(pfa_pkg::FMT_ARGB32));
		send_pixel(32'h8001_7FFE);
		for (int code = int'(pfa_pkg::FMT_ARGB32) + 1;
			code < (1 << $bits(pfa_pkg::FMT_ARGB32)); code++) begin
			settle_idle();
			write_reg(pfa_pkg::REG_PIXEL_FORMAT, code);
			send_pixel(32'hFFFF_FFFF);
		end
	endtask

	task automatic test_padding;
		settle_idle();
		write_reg(pfa_pkg::REG_PIXEL_FORMAT, 32'(pfa_pkg::FMT_ARGB32));
		write_reg(pfa_pkg::REG_IMAGE_WIDTH, 2);
		write_reg(pfa_pkg::REG_IMAGE_HEIGHT, 1);
		write_reg(pfa_pkg::REG_RECT_X, 1);
		write_reg(pfa_pkg::REG_RECT_Y, 0);
		write_reg(pfa_pkg::REG_RECT_WIDTH, 2);
		write_reg(pfa_pkg::REG_RECT_HEIGHT, 2);
		repeat (4) send_pixel($urandom);
		settle_idle();
		write_reg(pfa_pkg::REG_RECT_X, 5);
		send_pixel($urandom);
		settle_idle();
		write_reg(pfa_pkg::REG_RECT_X, 0);
		write_reg(pfa_pkg::REG_IMAGE_WIDTH, 0);
		send_pixel($urandom);
	endtask

	task automatic test_size_limits;
		settle_idle();
		write_reg(pfa_pkg::REG_PIXEL_FORMAT, 32'(pfa_pkg::FMT_XRGB32));
		write_reg(pfa_pkg::REG_IMAGE_WIDTH, 8191);
		write_reg(pfa_pkg::REG_IMAGE_HEIGHT, 8191);
		write_reg(pfa_pkg::REG_RECT_X, 4095);
		write_reg(pfa_pkg::REG_RECT_Y, 4095);
		write_reg(pfa_pkg::REG_RECT_WIDTH, 2);
		write_reg(pfa_pkg::REG_RECT_HEIGHT, 2);
		repeat (4) send_pixel($urandom);
		settle_idle();
		write_reg(pfa_pkg::REG_RECT_WIDTH, 0);
		write_reg(pfa_pkg::REG_RECT_HEIGHT, 0);
		send_pixel($urandom);
		settle_idle();
		write_reg(REG_UNUSED_INDEX, 8191);
		send_pixel($urandom);
	endtask

	// Shrinking the rectangle mid-stream leaves the counters past their new bounds.
	task automatic test_counter_wrap;
		settle_idle();
		write_reg(pfa_pkg::REG_PIXEL_FORMAT, 32'(pfa_pkg::FMT_RGB888));
		write_reg(pfa_pkg::REG_IMAGE_WIDTH, 4096);
		write_reg(pfa_pkg::REG_IMAGE_HEIGHT, 4096);
		write_reg(pfa_pkg::REG_RECT_X, 0);
		write_reg(pfa_pkg::REG_RECT_Y, 0);
		write_reg(pfa_pkg::REG_RECT_WIDTH, 4);
		write_reg(pfa_pkg::REG_RECT_HEIGHT, 3);
		repeat (5) send_pixel($urandom);
		settle_idle();
		write_reg(pfa_pkg::REG_RECT_WIDTH, 1);
		send_pixel($urandom);
		settle_idle();
		write_reg(pfa_pkg::REG_RECT_HEIGHT, 2);
		repeat (2) send_pixel($urandom);
	endtask

	task automatic test_tile_saturation;
		set_flow(13, 13);
		settle_idle();
		write_reg(pfa_pkg::REG_PIXEL_FORMAT, $urandom_range(0, 7));
		write_reg(pfa_pkg::REG_RECT_WIDTH, $urandom_range(TILE_LIMIT + 1, 1023));
		write_reg(pfa_pkg::REG_RECT_HEIGHT, 1);
		repeat (TILE_LIMIT + 8) send_pixel($urandom);
		settle_idle();
		write_reg(pfa_pkg::REG_RECT_WIDTH, 1);
		write_reg(pfa_pkg::REG_RECT_HEIGHT, $urandom_range(TILE_LIMIT + 1, 1023));
		repeat (TILE_LIMIT + 8) send_pixel($urandom);
	endtask

	task automatic test_random_streams;
		int unsigned count;
		logic [31:0] raw;
		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
				0: set_flow(0, 0);
				1: set_flow(85, 0);
				2: set_flow(0, 85);
				default: set_flow(13, 13);
			endcase
			repeat (4) begin
				settle_idle();
				write_reg(pfa_pkg::REG_PIXEL_FORMAT, $urandom_range(0, 7));
				for (int axis = 0; axis < 2; axis++) begin
					case ($urandom_range(0, 9))
						0: count = 0;
						1: count = $urandom_range(IMAGE_LIMIT + 1, 8191);
						default: count = $urandom_range(1, 12);
					endcase
					write_reg(axis == 0 ? pfa_pkg::REG_IMAGE_WIDTH : pfa_pkg::REG_IMAGE_HEIGHT,
						count);
					count = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) :
						$urandom_range(0, 10);
					write_reg(axis == 0 ? pfa_pkg::REG_RECT_X : pfa_pkg::REG_RECT_Y, count);
					count = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
					write_reg(axis == 0 ? pfa_pkg::REG_RECT_WIDTH : pfa_pkg::REG_RECT_HEIGHT,
						count);
				end
				count = $urandom_range(15, 70);
				repeat (count) begin
					raw = $urandom;
					if ($urandom_range(0, 3) == 0) begin
						raw[31:24] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					end
					send_pixel(raw);
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		raw_pixel = '0;
		mismatch_count = 0;
		pixels_sent = 0;
		reg_writes = 0;
		col_pos = 0;
		row_pos = 0;
		reg_shadow = '{pixel_format: pfa_pkg::FMT_RGB565, image_width: 13'd1,
			image_height: 13'd1, rect_x: 12'd0, rect_y: 12'd0, rect_width: 10'd1,
			rect_height: 10'd1};
		set_flow(0, 0);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_formats();
		test_padding();
		test_size_limits();
		test_counter_wrap();
		test_tile_saturation();
		test_random_streams();

		settle_idle();
		repeat (8) @(posedge clk);
		$display("Checked %0d pixel transactions after %0d register writes.",
			pixels_sent, reg_writes);
		$display("Run covered every format code, padding, size clamps and counter wrap.");
		if (mismatch_count == 0 && pending_argb.size() == 0) begin
			$display("pixel_format_to_argb32_top test passed");
		end else begin
			$display("pixel_format_to_argb32_top test failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/pfa_pkg.sv
rtl/core/pfa_cfg_regs.sv
rtl/core/pfa_position.sv
rtl/core/pfa_convert.sv
rtl/core/pixel_format_to_argb32_top.sv
test/pixel_format_to_argb32_top_test.sv
